@@ hw/rtl/ple_pkg.sv @@
package ple_pkg;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 5;
    localparam int STATUS_W = 2;

    localparam int S_DATA_W = ((CMD_W + POS_W + VALUE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((VALUE_W + LENGTH_W + STATUS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT_BACK  = 3'd0,
        CMD_POP_BACK  = 3'd1,
        CMD_PUT_FRONT = 3'd2,
        CMD_POP_FRONT = 3'd3,
        CMD_INSERT_AT = 3'd4,
        CMD_ERASE_AT  = 3'd5,
        CMD_CLEAR     = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_INSERT,
        OP_REMOVE,
        OP_CLEAR
    } op_t;

    typedef enum logic [1:0] {
        TGT_ZERO,
        TGT_COUNT,
        TGT_LAST,
        TGT_POS
    } tgt_sel_t;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic     load;
        op_t      op;
        tgt_sel_t tgt_sel;
        status_t  status;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic pos_gt_count;
        logic pos_ge_count;
    } dp_status_t;

endpackage

@@ hw/rtl/ple_ctrl.sv @@
module ple_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ple_pkg::CMD_W-1:0] cmd,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  ple_pkg::dp_status_t       dp_status,
    output ple_pkg::dp_cmd_t          dp_cmd
);
    import ple_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        s_tready   = (state_reg == S_IDLE) || m_tready;
        accept     = s_tvalid && s_tready;
        m_tvalid   = (state_reg == S_HOLD);
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_HOLD;
            end
            S_HOLD: begin
                if (accept) state_next = S_HOLD;
                else if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // command decode against the current list state
    always_comb begin
        dp_cmd.load    = accept;
        dp_cmd.op      = OP_NOP;
        dp_cmd.tgt_sel = TGT_ZERO;
        dp_cmd.status  = STAT_OK;
        case (cmd_t'(cmd))
            CMD_PUT_BACK: begin
                if (dp_status.full) begin
                    dp_cmd.status = STAT_FULL;
                end else begin
                    dp_cmd.op      = OP_INSERT;
                    dp_cmd.tgt_sel = TGT_COUNT;
                end
            end
            CMD_POP_BACK: begin
                if (dp_status.empty) begin
                    dp_cmd.status = STAT_EMPTY;
                end else begin
                    dp_cmd.op      = OP_REMOVE;
                    dp_cmd.tgt_sel = TGT_LAST;
                end
            end
            CMD_PUT_FRONT: begin
                if (dp_status.full) begin
                    dp_cmd.status = STAT_FULL;
                end else begin
                    dp_cmd.op = OP_INSERT;
                end
            end
            CMD_POP_FRONT: begin
                if (dp_status.empty) begin
                    dp_cmd.status = STAT_EMPTY;
                end else begin
                    dp_cmd.op = OP_REMOVE;
                end
            end
            CMD_INSERT_AT: begin
                if (dp_status.pos_gt_count) begin
                    dp_cmd.status = STAT_RANGE;
                end else if (dp_status.full) begin
                    dp_cmd.status = STAT_FULL;
                end else begin
                    dp_cmd.op      = OP_INSERT;
                    dp_cmd.tgt_sel = TGT_POS;
                end
            end
            CMD_ERASE_AT: begin
                if (dp_status.empty) begin
                    dp_cmd.status = STAT_EMPTY;
                end else if (dp_status.pos_ge_count) begin
                    dp_cmd.status = STAT_RANGE;
                end else begin
                    dp_cmd.op      = OP_REMOVE;
                    dp_cmd.tgt_sel = TGT_POS;
                end
            end
            CMD_CLEAR: begin
                dp_cmd.op = OP_CLEAR;
            end
            default: begin
                dp_cmd.op = OP_NOP;
            end
        endcase
    end

endmodule

@@ hw/rtl/ple_datapath.sv @@
module ple_datapath #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ple_pkg::POS_W-1:0]    position,
    input  logic [ple_pkg::VALUE_W-1:0]  value_in,
    input  ple_pkg::dp_cmd_t             dp_cmd,
    output ple_pkg::dp_status_t          dp_status,
    output logic [ple_pkg::VALUE_W-1:0]  value_out,
    output logic [ple_pkg::LENGTH_W-1:0] length,
    output logic [ple_pkg::STATUS_W-1:0] status
);
    import ple_pkg::*;

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [VALUE_W-1:0]  entries_reg [MAX_ENTRIES];
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       tgt;
    logic [VALUE_W-1:0]  removed;
    logic [VALUE_W-1:0]  value_out_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                do_insert;
    logic                do_remove;

    always_comb begin
        dp_status.empty        = (count_reg == '0);
        dp_status.full         = (count_reg == CW'(MAX_ENTRIES));
        dp_status.pos_gt_count = (CMPW'(position) > CMPW'(count_reg));
        dp_status.pos_ge_count = (CMPW'(position) >= CMPW'(count_reg));
    end

    always_comb begin
        case (dp_cmd.tgt_sel)
            TGT_ZERO:  tgt = '0;
            TGT_COUNT: tgt = count_reg;
            TGT_LAST:  tgt = count_reg - CW'(1);
            TGT_POS:   tgt = CW'(position);
            default:   tgt = '0;
        endcase
    end

    assign do_insert = dp_cmd.load && (dp_cmd.op == OP_INSERT);
    assign do_remove = dp_cmd.load && (dp_cmd.op == OP_REMOVE);
    assign removed   = entries_reg[tgt[IW-1:0]];

    always_comb begin
        count_next = count_reg;
        case (dp_cmd.op)
            OP_INSERT: count_next = count_reg + CW'(1);
            OP_REMOVE: count_next = count_reg - CW'(1);
            OP_CLEAR:  count_next = '0;
            default:   count_next = count_reg;
        endcase
    end

    // row of entry cells, each shifting from a neighbour or loading the new value
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        always_ff @(posedge aclk) begin
            if (do_insert) begin
                if (IDX == tgt) begin
                    entries_reg[i] <= value_in;
                end else if (IDX > tgt) begin
                    entries_reg[i] <= entries_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (do_remove) begin
                if ((IDX >= tgt) && (i < MAX_ENTRIES - 1)) begin
                    entries_reg[i] <= entries_reg[(i < MAX_ENTRIES - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (dp_cmd.load) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            value_out_reg <= do_remove ? removed : '0;
            length_reg    <= LENGTH_W'(count_next);
            status_reg    <= dp_cmd.status;
        end
    end

    assign value_out = value_out_reg;
    assign length    = length_reg;
    assign status    = status_reg;

endmodule

@@ hw/rtl/positional_list_engine.sv @@
// positional_list_engine: bounded ordered list of signed 32-bit values
//
// s_ channel carries one command per transaction (push/pop at either end,
// insert/erase at a position, clear); m_ channel returns exactly one
// result per command with the removed value, the new length and a status.
//
// latency: the result is valid on m_ in the cycle after the command
// transaction. throughput: one command per cycle while m_tready is high, set
// by the row of entry cells that all shift together and the result registers.
//
// while a result waits, s_tready follows m_tready, so a new command is
// taken in the same cycle the waiting result is taken; when the receiver
// stalls the result holds and no further command is taken.
//
// reset (aresetn low, synchronous) empties the list and drops any
// pending result; entry storage keeps its contents but is never read
// beyond the current length.
module positional_list_engine #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ple_pkg::S_DATA_W-1:0]  s_tdata,  // cmd, position, value_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ple_pkg::M_DATA_W-1:0]  m_tdata   // value_out, length, status, zero pad
);
    import ple_pkg::*;

    dp_cmd_t             dp_cmd;
    dp_status_t          dp_status;
    logic [VALUE_W-1:0]  value_out;
    logic [LENGTH_W-1:0] length;
    logic [STATUS_W-1:0] status;

    ple_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cmd       (s_tdata[CMD_W-1:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    ple_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .position  (s_tdata[CMD_W +: POS_W]),
        .value_in  (s_tdata[CMD_W + POS_W +: VALUE_W]),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .value_out (value_out),
        .length    (length),
        .status    (status)
    );

    assign m_tdata = M_DATA_W'({status, length, value_out});

endmodule

@@ hw/rtl/ple_checker.sv @@
module ple_checker #(
    parameter int MAX_ENTRIES = 16
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [ple_pkg::S_DATA_W-1:0] s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ple_pkg::M_DATA_W-1:0] m_tdata
);
    import ple_pkg::*;

    logic [VALUE_W-1:0]  chk_value;
    logic [LENGTH_W-1:0] chk_length;
    logic [STATUS_W-1:0] chk_status;

    assign chk_value  = m_tdata[VALUE_W-1:0];
    assign chk_length = m_tdata[VALUE_W +: LENGTH_W];
    assign chk_status = m_tdata[VALUE_W + LENGTH_W +: STATUS_W];

    // every command gives its result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("no result after command");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_full_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (chk_status == STAT_FULL)) |-> (chk_length == LENGTH_W'(MAX_ENTRIES)))
        else $error("full status with wrong length");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (chk_status == STAT_EMPTY)) |-> ((chk_length == '0) && (chk_value == '0)))
        else $error("empty status with non-empty result");

endmodule

bind positional_list_engine ple_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_ple_checker (.*);
